[hw/rtl/orpr_pkg.sv]
`timescale 1ns / 1ps
// Package for the OTDR peak reflectance unit: widths, fixed-point constants,
// datapath operation codes, controller states and command/status structs.
// No dependencies.
package orpr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int POS_W      = 16;
	localparam int REFL_W     = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// series length of e^-z and number of log2 fraction bits
	localparam int SERIES_TERMS = 20;
	localparam int LOG_BITS     = 24;

	localparam logic [63:0] Q60_ONE           = 64'h1000_0000_0000_0000;
	localparam logic [63:0] LN2_Q60           = 64'd2977044472 << 28;
	localparam logic [63:0] LOG2TEN_FIFTH_Q32 = 64'd2853514506;
	localparam logic [63:0] TEN_LOG10_TWO_Q28 = 64'd808071242;
	localparam logic [47:0] H_LIMIT_Q16       = 48'd2621440;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOPE,
		CFG_INTERCEPT,
		CFG_RAYLEIGH,
		CFG_SCALE
	} cfg_idx_t;

	// right shift applied to the 128 bit product
	typedef enum logic [1:0] {
		SH_0,
		SH_36,
		SH_48,
		SH_60
	} mul_sh_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_DIFF,
		OP_HDIV,
		OP_HSET,
		OP_UMUL,
		OP_USET,
		OP_ZMUL,
		OP_ZSET,
		OP_TMUL,
		OP_TDIV,
		OP_TSET,
		OP_XSET,
		OP_NORM,
		OP_SQMUL,
		OP_SQSET,
		OP_NLMUL,
		OP_CSET,
		OP_CZERO,
		OP_OUT,
		OP_OUTZ
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_CHK,
		ST_HDIV,
		ST_HCHK,
		ST_UMUL,
		ST_ZGO,
		ST_ZMUL,
		ST_TGO,
		ST_TMUL,
		ST_TDIV,
		ST_XSET,
		ST_NORM,
		ST_SQGO,
		ST_SQ,
		ST_NLGO,
		ST_NL,
		ST_OUT,
		ST_OUTZ
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   ready;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic snap_seen;
		logic diff_le0;
		logic h_zero;
		logic h_big;
		logic y_low;
		logic t_last;
		logic sq_last;
		logic out_full;
	} dp_stat_t;

endpackage

[hw/rtl/orpr_in_if.sv]
`timescale 1ns / 1ps
// Sample channel: valid/ready handshake with sample, position and last flag.
// Uses orpr_pkg for field widths.
interface orpr_in_if;
	logic                          valid;
	logic                          ready;
	logic [orpr_pkg::SAMPLE_W-1:0] sample;
	logic [orpr_pkg::POS_W-1:0]    position;
	logic                          last;

	modport source (output valid, sample, position, last, input ready);
	modport sink (input valid, sample, position, last, output ready);
endinterface

[hw/rtl/orpr_out_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with reflectance and peak fields.
// Uses orpr_pkg for field widths.
interface orpr_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [orpr_pkg::REFL_W-1:0] reflectance;
	logic                              peak_found;
	logic [orpr_pkg::POS_W-1:0]        peak_position;

	modport source (output valid, reflectance, peak_found, peak_position, input ready);
	modport sink (input valid, reflectance, peak_found, peak_position, output ready);
endinterface

[hw/rtl/orpr_mul.sv]
`timescale 1ns / 1ps
// 64x64 multiplier built from four sequential 32x32 partial products,
// returning bits [s+63:s] of the 128 bit product. Uses orpr_pkg.
module orpr_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	input  orpr_pkg::mul_sh_t     sh,
	output logic                  done,
	output logic [63:0]           res
);

	logic [63:0]        a_q, b_q;
	orpr_pkg::mul_sh_t  sh_q;
	logic [127:0]       acc_q;
	logic [63:0]        prod_s1;
	logic [1:0]         pidx_s1;
	logic [2:0]         cnt_q;
	logic               busy_q, done_q;
	logic [31:0]        a_part, b_part;
	logic [127:0]       prod_ext;

	// operand halves for the current partial product
	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (pidx_s1)
			2'd0:    prod_ext = {64'b0, prod_s1};
			2'd3:    prod_ext = {prod_s1, 64'b0};
			default: prod_ext = {32'b0, prod_s1, 32'b0};
		endcase
	end

	// control: busy while the partial products are summed, done pulse when the sum is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial product register and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				prod_s1 <= a_part * b_part;
				pidx_s1 <= cnt_q[1:0];
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + prod_ext;
		end
	end

	always_comb begin
		unique case (sh_q)
			orpr_pkg::SH_0:  res = acc_q[63:0];
			orpr_pkg::SH_36: res = acc_q[99:36];
			orpr_pkg::SH_48: res = acc_q[111:48];
			orpr_pkg::SH_60: res = acc_q[123:60];
			default:         res = acc_q[63:0];
		endcase
	end

	assign done = done_q;

endmodule

[hw/rtl/orpr_div.sv]
`timescale 1ns / 1ps
// Restoring divider, 64 bit dividend by nonzero 16 bit divisor, one
// quotient bit per cycle. No package dependencies.
module orpr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] dq_q;
	logic [15:0] rem_q, dv_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [16:0] shifted, trial;
	logic        ge;

	assign shifted = {rem_q, dq_q[63]};
	assign trial   = shifted - {1'b0, dv_q};
	assign ge      = shifted >= {1'b0, dv_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one subtract-and-shift step
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[15:0] : shifted[15:0];
			dq_q  <= {dq_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

[hw/rtl/orpr_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, peak tracker, height and log/exp
// arithmetic, output register. Uses orpr_pkg, orpr_mul and orpr_div.
module orpr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [orpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [orpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_accept,
	input  logic [orpr_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic [orpr_pkg::POS_W-1:0]      in_position,
	input  logic                            in_last,
	input  orpr_pkg::dp_cmd_t               cmd,
	output orpr_pkg::dp_stat_t              stat,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic signed [orpr_pkg::REFL_W-1:0] out_reflectance,
	output logic                            out_peak_found,
	output logic [orpr_pkg::POS_W-1:0]      out_peak_position
);

	// configuration
	logic signed [31:0] slope_q, intercept_q;
	logic signed [15:0] ray_q;
	logic [15:0]        sf_q;

	// tracker and window snapshot
	logic [orpr_pkg::SAMPLE_W-1:0] pv_q, snap_val_q;
	logic [orpr_pkg::POS_W-1:0]    pi_q, snap_idx_q;
	logic                          ps_q, snap_seen_q;
	logic                          upd;

	// arithmetic state
	logic signed [49:0] diff_q;
	logic [47:0]        h_q;
	logic [63:0]        u_q, z_q, term_q, sum_q, y_q;
	logic [5:0]         e_q;
	logic [23:0]        f_q;
	logic [4:0]         n_q;
	logic [24:0]        corr_q;

	// output register
	logic                               ov_q, of_q;
	logic signed [orpr_pkg::REFL_W-1:0] orefl_q;
	logic [orpr_pkg::POS_W-1:0]         opos_q;

	// unit hookup
	logic               mul_start, mul_done, div_start, div_done;
	logic [63:0]        mul_a, mul_b, mul_res, div_a, div_q;
	logic [15:0]        div_b;
	orpr_pkg::mul_sh_t  mul_sh;

	logic signed [48:0] idx_slope;
	logic signed [49:0] diff_d;
	logic [63:0]        x_d;
	logic [29:0]        neglog;
	logic signed [51:0] v_d;
	logic signed [43:0] q_d;
	logic signed [15:0] refl_d;

	orpr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.sh(mul_sh), .done(mul_done), .res(mul_res)
	);

	orpr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q     <= '0;
			intercept_q <= '0;
			ray_q       <= '0;
			sf_q        <= 16'd1;
		end else if (cfg_we) begin
			unique case (orpr_pkg::cfg_idx_t'(cfg_index))
				orpr_pkg::CFG_SLOPE:     slope_q     <= cfg_data;
				orpr_pkg::CFG_INTERCEPT: intercept_q <= cfg_data;
				orpr_pkg::CFG_RAYLEIGH:  ray_q       <= cfg_data[15:0];
				orpr_pkg::CFG_SCALE:     sf_q        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// first strict maximum above zero; cleared by the last sample
	assign upd = in_sample > pv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			pi_q <= '0;
			ps_q <= 1'b0;
		end else if (in_accept) begin
			if (in_last) begin
				pv_q <= '0;
				pi_q <= '0;
				ps_q <= 1'b0;
			end else if (upd) begin
				pv_q <= in_sample;
				pi_q <= in_position;
				ps_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && in_last) begin
			snap_val_q  <= upd ? in_sample : pv_q;
			snap_idx_q  <= upd ? in_position : pi_q;
			snap_seen_q <= upd | ps_q;
		end
	end

	// peak minus baseline, Q16.16
	assign idx_slope = $signed({1'b0, snap_idx_q}) * slope_q;
	assign diff_d    = $signed({18'b0, snap_val_q, 16'b0}) - 50'(idx_slope)
	                 - 50'(intercept_q);

	// 2^-k of the series sum, then 1 - that
	assign x_d    = sum_q >> u_q[63:48];
	assign neglog = {e_q, 24'b0} - {6'b0, f_q};

	// unit start requests
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		mul_sh    = orpr_pkg::SH_0;
		div_start = 1'b0;
		div_a     = '0;
		div_b     = 16'd1;
		unique case (cmd.op)
			orpr_pkg::OP_HDIV: begin
				div_start = 1'b1;
				div_a     = 64'(diff_q[47:0]);
				div_b     = (sf_q == 16'd0) ? 16'd1 : sf_q;
			end
			orpr_pkg::OP_UMUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(h_q);
				mul_b     = orpr_pkg::LOG2TEN_FIFTH_Q32;
			end
			orpr_pkg::OP_ZMUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(u_q[47:0]);
				mul_b     = orpr_pkg::LN2_Q60;
				mul_sh    = orpr_pkg::SH_48;
			end
			orpr_pkg::OP_TMUL: begin
				mul_start = 1'b1;
				mul_a     = term_q;
				mul_b     = z_q;
				mul_sh    = orpr_pkg::SH_60;
			end
			orpr_pkg::OP_TDIV: begin
				div_start = 1'b1;
				div_a     = mul_res;
				div_b     = 16'(n_q);
			end
			orpr_pkg::OP_SQMUL: begin
				mul_start = 1'b1;
				mul_a     = y_q;
				mul_b     = y_q;
				mul_sh    = orpr_pkg::SH_60;
			end
			orpr_pkg::OP_NLMUL: begin
				mul_start = 1'b1;
				mul_a     = 64'(neglog);
				mul_b     = orpr_pkg::TEN_LOG10_TWO_Q28;
				mul_sh    = orpr_pkg::SH_36;
			end
			default: ;
		endcase
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			orpr_pkg::OP_DIFF: diff_q <= diff_d;
			orpr_pkg::OP_HSET: h_q    <= div_q[47:0];
			orpr_pkg::OP_USET: u_q    <= mul_res;
			orpr_pkg::OP_ZSET: begin
				z_q    <= mul_res;
				term_q <= orpr_pkg::Q60_ONE;
				sum_q  <= orpr_pkg::Q60_ONE;
				n_q    <= 5'd1;
			end
			orpr_pkg::OP_TSET: begin
				term_q <= div_q;
				sum_q  <= n_q[0] ? (sum_q - div_q) : (sum_q + div_q);
				n_q    <= n_q + 5'd1;
			end
			orpr_pkg::OP_XSET: begin
				y_q <= (x_d < orpr_pkg::Q60_ONE) ? (orpr_pkg::Q60_ONE - x_d) : 64'd1;
				e_q <= '0;
				f_q <= '0;
				n_q <= '0;
			end
			orpr_pkg::OP_NORM: begin
				y_q <= {y_q[62:0], 1'b0};
				e_q <= e_q + 6'd1;
			end
			orpr_pkg::OP_SQSET: begin
				if (mul_res >= (orpr_pkg::Q60_ONE << 1)) begin
					y_q <= mul_res >> 1;
					f_q <= {f_q[22:0], 1'b1};
				end else begin
					y_q <= mul_res;
					f_q <= {f_q[22:0], 1'b0};
				end
				n_q <= n_q + 5'd1;
			end
			orpr_pkg::OP_CSET:  corr_q <= mul_res[24:0];
			orpr_pkg::OP_CZERO: corr_q <= '0;
			default: ;
		endcase
	end

	// 2h - correction + rayleigh, rounded half up to Q8.8 and saturated
	assign v_d = $signed({3'b0, h_q, 1'b0}) - $signed({27'b0, corr_q})
	           + $signed({{28{ray_q[15]}}, ray_q, 8'b0}) + 52'sd128;
	assign q_d = v_d[51:8];

	always_comb begin
		if (q_d > 44'sd32767)
			refl_d = 16'sd32767;
		else if (q_d < -44'sd32768)
			refl_d = -16'sd32768;
		else
			refl_d = q_d[15:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.op == orpr_pkg::OP_OUT || cmd.op == orpr_pkg::OP_OUTZ)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == orpr_pkg::OP_OUT || cmd.op == orpr_pkg::OP_OUTZ) begin
			orefl_q <= (cmd.op == orpr_pkg::OP_OUT) ? refl_d : '0;
			of_q    <= snap_seen_q;
			opos_q  <= snap_idx_q;
		end
	end

	assign out_valid         = ov_q;
	assign out_reflectance   = orefl_q;
	assign out_peak_found    = of_q;
	assign out_peak_position = opos_q;

	// status to the controller
	assign stat.mul_done  = mul_done;
	assign stat.div_done  = div_done;
	assign stat.snap_seen = snap_seen_q;
	assign stat.diff_le0  = diff_q[49] || (diff_q == '0);
	assign stat.h_zero    = (h_q == '0);
	assign stat.h_big     = (h_q > orpr_pkg::H_LIMIT_Q16);
	assign stat.y_low     = (y_q < orpr_pkg::Q60_ONE);
	assign stat.t_last    = (n_q == 5'(orpr_pkg::SERIES_TERMS));
	assign stat.sq_last   = (n_q == 5'(orpr_pkg::LOG_BITS - 1));
	assign stat.out_full  = ov_q && !out_ready;

endmodule

[hw/rtl/orpr_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences the datapath operations for one
// window's reflectance. Uses orpr_pkg.
module orpr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_accept,
	input  logic               in_last,
	input  orpr_pkg::dp_stat_t stat,
	output orpr_pkg::dp_cmd_t  cmd
);

	orpr_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= orpr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and command
	always_comb begin
		state_d   = state_q;
		cmd.op    = orpr_pkg::OP_NONE;
		cmd.ready = 1'b0;
		unique case (state_q)
			orpr_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (in_accept && in_last)
					state_d = orpr_pkg::ST_DIFF;
			end
			orpr_pkg::ST_DIFF: begin
				cmd.op  = orpr_pkg::OP_DIFF;
				state_d = orpr_pkg::ST_CHK;
			end
			orpr_pkg::ST_CHK: begin
				if (!stat.snap_seen || stat.diff_le0) begin
					state_d = orpr_pkg::ST_OUTZ;
				end else begin
					cmd.op  = orpr_pkg::OP_HDIV;
					state_d = orpr_pkg::ST_HDIV;
				end
			end
			orpr_pkg::ST_HDIV: begin
				if (stat.div_done) begin
					cmd.op  = orpr_pkg::OP_HSET;
					state_d = orpr_pkg::ST_HCHK;
				end
			end
			orpr_pkg::ST_HCHK: begin
				if (stat.h_zero) begin
					state_d = orpr_pkg::ST_OUTZ;
				end else if (stat.h_big) begin
					cmd.op  = orpr_pkg::OP_CZERO;
					state_d = orpr_pkg::ST_OUT;
				end else begin
					cmd.op  = orpr_pkg::OP_UMUL;
					state_d = orpr_pkg::ST_UMUL;
				end
			end
			orpr_pkg::ST_UMUL: begin
				if (stat.mul_done) begin
					cmd.op  = orpr_pkg::OP_USET;
					state_d = orpr_pkg::ST_ZGO;
				end
			end
			orpr_pkg::ST_ZGO: begin
				cmd.op  = orpr_pkg::OP_ZMUL;
				state_d = orpr_pkg::ST_ZMUL;
			end
			orpr_pkg::ST_ZMUL: begin
				if (stat.mul_done) begin
					cmd.op  = orpr_pkg::OP_ZSET;
					state_d = orpr_pkg::ST_TGO;
				end
			end
			// series term: term*z, then divide by n
			orpr_pkg::ST_TGO: begin
				cmd.op  = orpr_pkg::OP_TMUL;
				state_d = orpr_pkg::ST_TMUL;
			end
			orpr_pkg::ST_TMUL: begin
				if (stat.mul_done) begin
					cmd.op  = orpr_pkg::OP_TDIV;
					state_d = orpr_pkg::ST_TDIV;
				end
			end
			orpr_pkg::ST_TDIV: begin
				if (stat.div_done) begin
					cmd.op  = orpr_pkg::OP_TSET;
					state_d = stat.t_last ? orpr_pkg::ST_XSET : orpr_pkg::ST_TGO;
				end
			end
			orpr_pkg::ST_XSET: begin
				cmd.op  = orpr_pkg::OP_XSET;
				state_d = orpr_pkg::ST_NORM;
			end
			orpr_pkg::ST_NORM: begin
				if (stat.y_low)
					cmd.op = orpr_pkg::OP_NORM;
				else
					state_d = orpr_pkg::ST_SQGO;
			end
			// log2 fraction by repeated squaring
			orpr_pkg::ST_SQGO: begin
				cmd.op  = orpr_pkg::OP_SQMUL;
				state_d = orpr_pkg::ST_SQ;
			end
			orpr_pkg::ST_SQ: begin
				if (stat.mul_done) begin
					cmd.op  = orpr_pkg::OP_SQSET;
					state_d = stat.sq_last ? orpr_pkg::ST_NLGO : orpr_pkg::ST_SQGO;
				end
			end
			orpr_pkg::ST_NLGO: begin
				cmd.op  = orpr_pkg::OP_NLMUL;
				state_d = orpr_pkg::ST_NL;
			end
			orpr_pkg::ST_NL: begin
				if (stat.mul_done) begin
					cmd.op  = orpr_pkg::OP_CSET;
					state_d = orpr_pkg::ST_OUT;
				end
			end
			orpr_pkg::ST_OUT: begin
				if (!stat.out_full) begin
					cmd.op  = orpr_pkg::OP_OUT;
					state_d = orpr_pkg::ST_IDLE;
				end
			end
			orpr_pkg::ST_OUTZ: begin
				if (!stat.out_full) begin
					cmd.op  = orpr_pkg::OP_OUTZ;
					state_d = orpr_pkg::ST_IDLE;
				end
			end
			default: state_d = orpr_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == orpr_pkg::OP_OUT || cmd.op == orpr_pkg::OP_OUTZ) |-> !stat.out_full)
		else $error("result loaded over a waiting result");

	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> (state_q == orpr_pkg::ST_UMUL || state_q == orpr_pkg::ST_ZMUL ||
			state_q == orpr_pkg::ST_TMUL || state_q == orpr_pkg::ST_SQ ||
			state_q == orpr_pkg::ST_NL))
		else $error("multiplier finished outside a wait state");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == orpr_pkg::ST_HDIV || state_q == orpr_pkg::ST_TDIV))
		else $error("divider finished outside a wait state");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_last) |=> (state_q == orpr_pkg::ST_DIFF))
		else $error("last request did not start the computation");
`endif

endmodule

[hw/rtl/otdr_peak_reflectance_unit.sv]
`timescale 1ns / 1ps
// OTDR peak reflectance unit. Samples that are not last are taken one per cycle.
// A last sample starts the computation; input is held off until it is done.
// The result is zero with no peak, with a baseline at or above the peak, or when
// the height divides to zero. Above 40 dB the correction is skipped; otherwise
// each of the 20 series terms runs the 64-step divider before the log2 squaring.
// Reset clears the tracker, configuration, controller state and output valid.
module otdr_peak_reflectance_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [orpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [orpr_pkg::CFG_DATA_W-1:0] cfg_data,
	orpr_in_if.sink                         in_ch,
	orpr_out_if.source                      out_ch
);

	orpr_pkg::dp_cmd_t  cmd;
	orpr_pkg::dp_stat_t stat;
	logic               in_accept;

	assign in_ch.ready = cmd.ready;
	assign in_accept   = in_ch.valid && cmd.ready;

	orpr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_accept(in_accept), .in_last(in_ch.last),
		.stat(stat), .cmd(cmd)
	);

	orpr_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_accept(in_accept), .in_sample(in_ch.sample),
		.in_position(in_ch.position), .in_last(in_ch.last),
		.cmd(cmd), .stat(stat),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.out_reflectance(out_ch.reflectance), .out_peak_found(out_ch.peak_found),
		.out_peak_position(out_ch.peak_position)
	);

endmodule
